>>> rtl/hcm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and register codes for the HSV chroma key matte unit.
// No dependencies; imported by the top level and its checker.
package hcm_pkg;

  // Default channel width in bits
  localparam int HCM_CHANNEL_BITS = 16;

  // Configuration port geometry
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int THR_W      = 16;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] KEY_RGB_RST = '1;
  localparam logic [THR_W-1:0]      HUE_THR_RST = 16'd655;
  localparam logic [THR_W-1:0]      SAT_TOL_RST = 16'd6554;
  localparam logic [THR_W-1:0]      VAL_TOL_RST = 16'd6554;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RGB = 2'd0,
    REG_HUE_THR = 2'd1,
    REG_SAT_TOL = 2'd2,
    REG_VAL_TOL = 2'd3
  } hcm_reg_e;

endpackage

>>> rtl/hsv_chroma_key_matte_unit.sv
`timescale 1ns / 1ps
// Results pass through P1, divider stages 0..W, H, K, M, X and the output register.
// Throughput: one pixel per cycle while in_stall_o is low; hue and saturation come from restoring dividers
// unrolled one quotient bit per pipeline stage, so depth grows with CHANNEL_BITS.
// Reset: registers take their defaults and the pipeline empties. The key color is
// then converted to HSV through the prep, load, divide and done steps, with
// in_stall_o held high; every key color write repeats that pass.
// Depends on hcm_pkg.
module hsv_chroma_key_matte_unit import hcm_pkg::*; #(
  parameter int CHANNEL_BITS = HCM_CHANNEL_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Pixel requests
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CHANNEL_BITS-1:0] in_red_i,
  input  logic [CHANNEL_BITS-1:0] in_green_i,
  input  logic [CHANNEL_BITS-1:0] in_blue_i,
  input  logic [CHANNEL_BITS-1:0] in_alpha_i,
  // Keyed results
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHANNEL_BITS-1:0] out_red_o,
  output logic [CHANNEL_BITS-1:0] out_green_o,
  output logic [CHANNEL_BITS-1:0] out_blue_o,
  output logic [CHANNEL_BITS-1:0] out_alpha_o,
  output logic [CHANNEL_BITS-1:0] matte_level_o,
  // Register writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int W  = CHANNEL_BITS;
  localparam int HW = W + 3;
  localparam int CW = $clog2(W);
  localparam int KW = (3 * W > CFG_DATA_W) ? 3 * W : CFG_DATA_W;
  localparam int TW = (W > THR_W) ? W : THR_W;

  // Hue circle: 6*M units per turn
  localparam logic [HW-1:0]  CH_MAX_H   = {3'b000, {W{1'b1}}};
  localparam logic [HW-1:0]  HUE_120    = CH_MAX_H << 1;
  localparam logic [HW-1:0]  HUE_240    = CH_MAX_H << 2;
  localparam logic [HW-1:0]  HUE_CIRCLE = HUE_120 + HUE_240;
  // M/2 rounding term for the matte product
  localparam logic [2*W-1:0] ROUND_HALF = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};

  // Key conversion sequencer states
  localparam logic [2:0] KS_IDLE = 3'd0;
  localparam logic [2:0] KS_PREP = 3'd1;
  localparam logic [2:0] KS_INIT = 3'd2;
  localparam logic [2:0] KS_DIV  = 3'd3;
  localparam logic [2:0] KS_DONE = 3'd4;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic [W-1:0] vmax;
    logic [W-1:0] chroma;
    logic [W-1:0] diff;
    logic         neg;
    sector_e      sector;
  } prep_t;

  // One restoring divider: partial remainder and numerator/quotient shifter
  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] lq;
  } lane_t;

  typedef struct packed {
    logic [3:0][W-1:0] chan;
    prep_t             prep;
  } p1_t;

  typedef struct packed {
    logic [3:0][W-1:0] chan;
    logic [W-1:0]      vmax;
    logic [W-1:0]      chroma;
    logic              neg;
    sector_e           sector;
    lane_t             hue_ln;
    lane_t             sat_ln;
  } div_t;

  typedef struct packed {
    logic [3:0][W-1:0] chan;
    logic [HW-1:0]     hue;
    logic [W-1:0]      sat;
    logic [W-1:0]      val;
  } hsv_st_t;

  typedef struct packed {
    logic [3:0][W-1:0] chan;
    logic [HW-1:0]     hue_dist;
    logic              sat_ok;
    logic              val_ok;
  } dist_st_t;

  typedef struct packed {
    logic [3:0][W-1:0] chan;
    logic [W-1:0]      matte;
  } matte_st_t;

  typedef struct packed {
    logic [3:0][2*W-1:0] prod;
    logic [W-1:0]        matte;
  } prod_st_t;

  // Max, min, chroma and the signed hue numerator of one color
  function automatic prep_t hsv_prep(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
    logic [W-1:0] vmin;
    prep_t        p;
    p.vmax = r;
    if (g > p.vmax) p.vmax = g;
    if (b > p.vmax) p.vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    p.chroma = p.vmax - vmin;
    if (r >= g && r >= b) begin
      p.sector = SECT_RED;
      p.neg    = (g < b);
      p.diff   = p.neg ? b - g : g - b;
    end else if (g >= b) begin
      p.sector = SECT_GREEN;
      p.neg    = (b < r);
      p.diff   = p.neg ? r - b : b - r;
    end else begin
      p.sector = SECT_BLUE;
      p.neg    = (r < g);
      p.diff   = p.neg ? g - r : r - g;
    end
    return p;
  endfunction

  // Load a divider with M * x; the high half is already below the divisor
  function automatic lane_t lane_load(logic [W-1:0] x);
    logic [2*W-1:0] num;
    lane_t          ln;
    num    = {x, {W{1'b0}}} - {{W{1'b0}}, x};
    ln.rem = num[2*W-1:W];
    ln.lq  = num[W-1:0];
    return ln;
  endfunction

  // One restoring division step: shift in a numerator bit, shift out a quotient bit
  function automatic lane_t lane_step(lane_t cur, logic [W-1:0] dvs);
    logic [W:0] trial;
    logic [W:0] rest;
    lane_t      nxt;
    trial = {cur.rem, cur.lq[W-1]};
    rest  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      nxt.rem = rest[W-1:0];
      nxt.lq  = {cur.lq[W-2:0], 1'b1};
    end else begin
      nxt.rem = trial[W-1:0];
      nxt.lq  = {cur.lq[W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // Place the hue quotient on the circle; negative slopes round the quotient up
  function automatic logic [HW-1:0] hue_final(sector_e sector, logic neg,
                                              logic [W-1:0] chroma, lane_t ln);
    logic [HW-1:0] base;
    logic [HW-1:0] q_ext;
    logic [HW-1:0] up_ext;
    logic [HW-1:0] hue;
    q_ext  = HW'(ln.lq);
    up_ext = HW'(ln.rem != '0);
    unique case (sector)
      SECT_RED:   base = neg ? HUE_CIRCLE : '0;
      SECT_GREEN: base = HUE_120;
      default:    base = HUE_240;
    endcase
    hue = neg ? base - q_ext - up_ext : base + q_ext;
    if (chroma == '0) hue = '0;
    return hue;
  endfunction

  function automatic logic [W-1:0] sat_final(logic [W-1:0] vmax, lane_t ln);
    return (vmax == '0) ? '0 : ln.lq;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] key_rgb_q;
  logic [THR_W-1:0]      hue_thr_q;
  logic [THR_W-1:0]      sat_tol_q;
  logic [THR_W-1:0]      val_tol_q;
  logic                  key_start;

  assign key_start = cfg_we_i && (cfg_idx_i == REG_KEY_RGB);

  // Store register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_rgb_q <= KEY_RGB_RST;
      hue_thr_q <= HUE_THR_RST;
      sat_tol_q <= SAT_TOL_RST;
      val_tol_q <= VAL_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (hcm_reg_e'(cfg_idx_i))
        REG_KEY_RGB: key_rgb_q <= cfg_data_i;
        REG_HUE_THR: hue_thr_q <= cfg_data_i[THR_W-1:0];
        REG_SAT_TOL: sat_tol_q <= cfg_data_i[THR_W-1:0];
        REG_VAL_TOL: val_tol_q <= cfg_data_i[THR_W-1:0];
      endcase
    end
  end

  // Fit tolerances and key fields to the channel width
  logic [TW-1:0] hue_thr_x, sat_tol_x, val_tol_x;
  logic [W-1:0]  hue_thr_w, sat_tol_w, val_tol_w;
  logic [KW-1:0] key_x;
  logic [W-1:0]  key_red, key_green, key_blue;

  assign hue_thr_x = TW'(hue_thr_q);
  assign sat_tol_x = TW'(sat_tol_q);
  assign val_tol_x = TW'(val_tol_q);
  assign hue_thr_w = hue_thr_x[W-1:0];
  assign sat_tol_w = sat_tol_x[W-1:0];
  assign val_tol_w = val_tol_x[W-1:0];
  assign key_x     = KW'(key_rgb_q);
  assign key_red   = key_x[3*W-1:2*W];
  assign key_green = key_x[2*W-1:W];
  assign key_blue  = key_x[W-1:0];

  // ---------------------------------------------------------------------------
  // Key color to HSV: one divider step per cycle each for hue and saturation
  // ---------------------------------------------------------------------------
  logic [2:0]    key_st_q, key_st_d;
  logic [CW-1:0] key_cnt_q, key_cnt_d;
  prep_t         key_prep_q;
  lane_t         key_hue_ln_q, key_sat_ln_q;
  logic [HW-1:0] key_hue_q;
  logic [W-1:0]  key_sat_q, key_val_q;
  logic          key_busy;

  assign key_busy = (key_st_q != KS_IDLE);

  // Sequence prep, load, W division steps and the final result
  always_comb begin
    key_st_d  = key_st_q;
    key_cnt_d = key_cnt_q;
    unique case (key_st_q)
      KS_PREP: key_st_d = KS_INIT;
      KS_INIT: begin
        key_st_d  = KS_DIV;
        key_cnt_d = CW'(W - 1);
      end
      KS_DIV: begin
        if (key_cnt_q == '0) begin
          key_st_d = KS_DONE;
        end else begin
          key_cnt_d = key_cnt_q - 1'b1;
        end
      end
      KS_DONE: key_st_d = KS_IDLE;
      default: key_st_d = KS_IDLE;
    endcase
    // Restart on every key write
    if (key_start) key_st_d = KS_PREP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_st_q  <= KS_PREP;
      key_cnt_q <= '0;
    end else begin
      key_st_q  <= key_st_d;
      key_cnt_q <= key_cnt_d;
    end
  end

  // Key datapath
  always_ff @(posedge clk_i) begin
    unique case (key_st_q)
      KS_PREP: key_prep_q <= hsv_prep(key_red, key_green, key_blue);
      KS_INIT: begin
        key_hue_ln_q <= lane_load(key_prep_q.diff);
        key_sat_ln_q <= lane_load(key_prep_q.chroma);
      end
      KS_DIV: begin
        key_hue_ln_q <= lane_step(key_hue_ln_q, key_prep_q.chroma);
        key_sat_ln_q <= lane_step(key_sat_ln_q, key_prep_q.vmax);
      end
      KS_DONE: begin
        key_hue_q <= hue_final(key_prep_q.sector, key_prep_q.neg, key_prep_q.chroma,
                               key_hue_ln_q);
        key_sat_q <= sat_final(key_prep_q.vmax, key_sat_ln_q);
        key_val_q <= key_prep_q.vmax;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pixel pipeline: P1, divider stages 0..W, H, K, M, X, output
  // ---------------------------------------------------------------------------
  logic       p1_vld_q, h_vld_q, k_vld_q, m_vld_q, x_vld_q, out_vld_q;
  logic [W:0] div_vld_q;
  logic       p1_adv, h_adv, k_adv, m_adv, x_adv, out_adv;
  logic [W:0] div_adv;
  logic       in_accept;

  p1_t       p1_q;
  div_t      div_q [0:W];
  hsv_st_t   h_q;
  dist_st_t  k_q;
  matte_st_t m_q;
  prod_st_t  x_q;
  logic [3:0][W-1:0] out_chan_q;
  logic [W-1:0]      out_matte_q;

  // A stage advances when it is empty or its successor advances
  assign out_adv = !out_vld_q || !out_stall_i;
  assign x_adv   = !x_vld_q || out_adv;
  assign m_adv   = !m_vld_q || x_adv;
  assign k_adv   = !k_vld_q || m_adv;
  assign h_adv   = !h_vld_q || k_adv;
  assign div_adv[W] = !div_vld_q[W] || h_adv;
  for (genvar k = 0; k < W; k++) begin : g_adv
    assign div_adv[k] = !div_vld_q[k] || div_adv[k+1];
  end
  assign p1_adv = !p1_vld_q || div_adv[0];

  // Hold requests while the pipeline is full or the key is being converted
  assign in_stall_o = key_busy || !p1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      div_vld_q <= '0;
      h_vld_q   <= 1'b0;
      k_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      x_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (p1_adv) p1_vld_q <= in_accept;
      if (div_adv[0]) div_vld_q[0] <= p1_vld_q;
      for (int k = 1; k <= W; k++) begin
        if (div_adv[k]) div_vld_q[k] <= div_vld_q[k-1];
      end
      if (h_adv) h_vld_q <= div_vld_q[W];
      if (k_adv) k_vld_q <= h_vld_q;
      if (m_adv) m_vld_q <= k_vld_q;
      if (x_adv) x_vld_q <= m_vld_q;
      if (out_adv) out_vld_q <= x_vld_q;
    end
  end

  // P1: max, min and slope of the pixel
  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      p1_q.chan <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
      p1_q.prep <= hsv_prep(in_red_i, in_green_i, in_blue_i);
    end
  end

  // Divider stage 0: form M * slope and M * chroma
  always_ff @(posedge clk_i) begin
    if (div_adv[0]) begin
      div_q[0].chan   <= p1_q.chan;
      div_q[0].vmax   <= p1_q.prep.vmax;
      div_q[0].chroma <= p1_q.prep.chroma;
      div_q[0].neg    <= p1_q.prep.neg;
      div_q[0].sector <= p1_q.prep.sector;
      div_q[0].hue_ln <= lane_load(p1_q.prep.diff);
      div_q[0].sat_ln <= lane_load(p1_q.prep.chroma);
    end
  end

  // Divider stages 1..W: one quotient bit each for hue and saturation
  for (genvar k = 1; k <= W; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (div_adv[k]) begin
        div_q[k].chan   <= div_q[k-1].chan;
        div_q[k].vmax   <= div_q[k-1].vmax;
        div_q[k].chroma <= div_q[k-1].chroma;
        div_q[k].neg    <= div_q[k-1].neg;
        div_q[k].sector <= div_q[k-1].sector;
        div_q[k].hue_ln <= lane_step(div_q[k-1].hue_ln, div_q[k-1].chroma);
        div_q[k].sat_ln <= lane_step(div_q[k-1].sat_ln, div_q[k-1].vmax);
      end
    end
  end

  // H: finish hue, saturation and value
  always_ff @(posedge clk_i) begin
    if (h_adv) begin
      h_q.chan <= div_q[W].chan;
      h_q.hue  <= hue_final(div_q[W].sector, div_q[W].neg, div_q[W].chroma,
                            div_q[W].hue_ln);
      h_q.sat  <= sat_final(div_q[W].vmax, div_q[W].sat_ln);
      h_q.val  <= div_q[W].vmax;
    end
  end

  // K: distances to the key
  logic [W-1:0] sat_diff, val_diff;

  assign sat_diff = (h_q.sat >= key_sat_q) ? h_q.sat - key_sat_q : key_sat_q - h_q.sat;
  assign val_diff = (h_q.val >= key_val_q) ? h_q.val - key_val_q : key_val_q - h_q.val;

  always_ff @(posedge clk_i) begin
    if (k_adv) begin
      k_q.chan     <= h_q.chan;
      k_q.hue_dist <= (h_q.hue >= key_hue_q) ? h_q.hue - key_hue_q : key_hue_q - h_q.hue;
      k_q.sat_ok   <= (sat_diff < sat_tol_w);
      k_q.val_ok   <= (val_diff < val_tol_w);
    end
  end

  // M: hue test direct or around the wrap, then pick the matte
  logic [HW-1:0] half_hue;
  logic          hue_ok;

  assign half_hue = HW'(hue_thr_w) + (HW'(hue_thr_w) << 1);
  assign hue_ok   = (k_q.hue_dist < half_hue) || ((HUE_CIRCLE - k_q.hue_dist) < half_hue);

  always_ff @(posedge clk_i) begin
    if (m_adv) begin
      m_q.chan  <= k_q.chan;
      m_q.matte <= (hue_ok && k_q.sat_ok && k_q.val_ok) ? '0 : k_q.chan[3];
    end
  end

  // X: channel times matte plus half an LSB of the result
  always_ff @(posedge clk_i) begin
    if (x_adv) begin
      for (int i = 0; i < 4; i++) begin
        x_q.prod[i] <= {{W{1'b0}}, m_q.chan[i]} * {{W{1'b0}}, m_q.matte} + ROUND_HALF;
      end
      x_q.matte <= m_q.matte;
    end
  end

  // Output: divide by 2^W - 1 as (p + (p >> W) + 1) >> W
  logic [3:0][2*W:0] div_m_sum;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      div_m_sum[i] = {1'b0, x_q.prod[i]} + (2*W+1)'(x_q.prod[i][2*W-1:W]) + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      for (int i = 0; i < 4; i++) begin
        out_chan_q[i] <= div_m_sum[i][2*W-1:W];
      end
      out_matte_q <= x_q.matte;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_red_o     = out_chan_q[0];
  assign out_green_o   = out_chan_q[1];
  assign out_blue_o    = out_chan_q[2];
  assign out_alpha_o   = out_chan_q[3];
  assign matte_level_o = out_matte_q;

endmodule

>>> rtl/hcm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the HSV chroma key matte unit, bound to the top level.
// Depends on hcm_pkg.
module hcm_checker import hcm_pkg::*; #(
  parameter int CHANNEL_BITS = HCM_CHANNEL_BITS
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [CHANNEL_BITS-1:0] out_red_o,
  input logic [CHANNEL_BITS-1:0] out_green_o,
  input logic [CHANNEL_BITS-1:0] out_blue_o,
  input logic [CHANNEL_BITS-1:0] out_alpha_o,
  input logic [CHANNEL_BITS-1:0] matte_level_o,
  input logic                    cfg_we_i,
  input logic [CFG_IDX_W-1:0]    cfg_idx_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_red_o) &&
    $stable(out_green_o) && $stable(out_blue_o) && $stable(out_alpha_o) &&
    $stable(matte_level_o))
    else $error("stalled result changed");

  // Scaled channels never exceed the matte, so a keyed pixel is all zero
  a_scaled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_red_o <= matte_level_o && out_green_o <= matte_level_o &&
    out_blue_o <= matte_level_o && out_alpha_o <= matte_level_o)
    else $error("scaled channel above matte");

  // Block requests while the key is converted after reset
  a_reset_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken before key conversion");

  // Block requests while a new key color is converted
  a_key_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_KEY_RGB |=> in_stall_o)
    else $error("request taken during key update");

endmodule

bind hsv_chroma_key_matte_unit hcm_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hcm_checker (.*);
